### rtl/core/tcwqs_pkg.sv
// tcwqs_pkg: shared types and constants of the two-class weighted queue scheduler
// word structs, command and status groups, controller states, kind and status codes
// no dependencies

package tcwqs_pkg;

   localparam int QUEUE_DEPTH_DEF = 16;

   localparam int ID_W     = 16;
   localparam int KIND_W   = 2;
   localparam int STATUS_W = 2;
   localparam int PERIOD_W = 4;

   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 4'd3;

   localparam logic [KIND_W-1:0] KIND_ENQ_NORMAL   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ENQ_PRIORITY = 2'd1;
   localparam logic [KIND_W-1:0] KIND_SERVE        = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_ENQUEUED = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_DROPPED  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_SERVED   = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_NONE     = 2'd3;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [ID_W-1:0]   client_id;
   } req_word_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ID_W-1:0]     served_id;
      logic                served_priority;
   } rsp_word_type;

   typedef struct packed {
      logic capture;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } sts_type;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

endpackage

### rtl/core/two_class_weighted_queue_scheduler.sv
// Two-class weighted queue scheduler: a normal and a priority queue sharing one serve port.
// Each word passes an accept state, which reads both queue heads from their memories, and
// then an execute state, which updates pointers, counts, phase and the output register, so
// req_stall is high during execute. The result waits in an output register while the next
// word is accepted; execute holds only while that register is still full and stalled. The
// queue memories need no clearing after reset. Uses tcwqs_pkg, tcwqs_ctrl and tcwqs_dp.

module two_class_weighted_queue_scheduler #(
   parameter int QUEUE_DEPTH = tcwqs_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  tcwqs_pkg::req_word_type        req_word,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output tcwqs_pkg::rsp_word_type        rsp_word,
   input  logic                           csr_write_en,
   input  logic [tcwqs_pkg::PERIOD_W-1:0] csr_write_data
);
   import tcwqs_pkg::*;

   cmd_type cmd;
   sts_type sts;

   tcwqs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   tcwqs_dp #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_word       (req_word),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_word       (rsp_word),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .cmd            (cmd),
      .sts            (sts)
   );

endmodule

### rtl/core/tcwqs_ctrl.sv
// tcwqs_ctrl: controller state machine of the queue scheduler
// sequences capture and commit of each word; uses tcwqs_pkg

module tcwqs_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output tcwqs_pkg::cmd_type cmd,
   input  tcwqs_pkg::sts_type sts
);
   import tcwqs_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      cmd.capture = 1'b0;
      cmd.commit  = 1'b0;
      req_stall   = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (sts.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

### rtl/core/tcwqs_dp.sv
// tcwqs_dp: datapath of the queue scheduler
// two queue memories, pointers, counts, serve phase, period register, output register
// uses tcwqs_pkg; driven by tcwqs_ctrl commands

module tcwqs_dp #(
   parameter int QUEUE_DEPTH = tcwqs_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  tcwqs_pkg::req_word_type          req_word,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output tcwqs_pkg::rsp_word_type          rsp_word,
   input  logic                             csr_write_en,
   input  logic [tcwqs_pkg::PERIOD_W-1:0]   csr_write_data,
   input  tcwqs_pkg::cmd_type               cmd,
   output tcwqs_pkg::sts_type               sts
);
   import tcwqs_pkg::*;

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [AW-1:0] PTR_LAST = AW'(QUEUE_DEPTH - 1);
   localparam logic [CW-1:0] CNT_FULL = CW'(QUEUE_DEPTH);

   logic [ID_W-1:0] n_mem [QUEUE_DEPTH];
   logic [ID_W-1:0] p_mem [QUEUE_DEPTH];

   req_word_type    item_ff;
   logic [ID_W-1:0] n_rd_ff, p_rd_ff;
   logic [AW-1:0]   n_head_ff, n_tail_ff, p_head_ff, p_tail_ff;
   logic [AW-1:0]   n_head_in, n_tail_in, p_head_in, p_tail_in;
   logic [CW-1:0]   n_cnt_ff, p_cnt_ff, n_cnt_in, p_cnt_in;
   logic [PERIOD_W-1:0] phase_ff, phase_in, period_ff, period_eff, phase_inc;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_word_type    rsp_word_ff, rsp_word_in;
   logic            n_wr, p_wr, n_pop, p_pop;
   logic            n_empty, p_empty, pick_prio;

   function automatic logic [AW-1:0] ptr_next(input logic [AW-1:0] ptr);
      ptr_next = (ptr == PTR_LAST) ? '0 : ptr + AW'(1);
   endfunction

   // queue memories
   always_ff @(posedge clock) begin
      if (n_wr) begin
         n_mem[n_tail_ff] <= item_ff.client_id;
      end
      if (p_wr) begin
         p_mem[p_tail_ff] <= item_ff.client_id;
      end
      if (cmd.capture) begin
         n_rd_ff <= n_mem[n_head_ff];
         p_rd_ff <= p_mem[p_head_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_ff <= req_word;
      end
      if (cmd.commit) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   always_comb begin
      n_empty    = (n_cnt_ff == '0);
      p_empty    = (p_cnt_ff == '0);
      period_eff = (period_ff == '0) ? PERIOD_W'(1) : period_ff;
      pick_prio  = (phase_ff == '0) ? !p_empty : n_empty;
      phase_inc  = phase_ff + PERIOD_W'(1);

      n_wr = 1'b0;
      p_wr = 1'b0;
      n_pop = 1'b0;
      p_pop = 1'b0;
      phase_in = phase_ff;
      rsp_word_in.status          = STATUS_NONE;
      rsp_word_in.served_id       = '0;
      rsp_word_in.served_priority = 1'b0;

      case (item_ff.kind)
         KIND_ENQ_NORMAL: begin
            if (n_cnt_ff == CNT_FULL) begin
               rsp_word_in.status = STATUS_DROPPED;
            end else begin
               rsp_word_in.status = STATUS_ENQUEUED;
               n_wr = cmd.commit;
            end
         end
         KIND_ENQ_PRIORITY: begin
            if (p_cnt_ff == CNT_FULL) begin
               rsp_word_in.status = STATUS_DROPPED;
            end else begin
               rsp_word_in.status = STATUS_ENQUEUED;
               p_wr = cmd.commit;
            end
         end
         KIND_SERVE: begin
            if (!n_empty || !p_empty) begin
               rsp_word_in.status          = STATUS_SERVED;
               rsp_word_in.served_priority = pick_prio;
               rsp_word_in.served_id       = pick_prio ? p_rd_ff : n_rd_ff;
               p_pop = cmd.commit && pick_prio;
               n_pop = cmd.commit && !pick_prio;
               if (cmd.commit) begin
                  phase_in = (phase_inc >= period_eff) ? '0 : phase_inc;
               end
            end
         end
         default: begin
            rsp_word_in.status = STATUS_NONE;
         end
      endcase

      n_tail_in = n_wr  ? ptr_next(n_tail_ff) : n_tail_ff;
      p_tail_in = p_wr  ? ptr_next(p_tail_ff) : p_tail_ff;
      n_head_in = n_pop ? ptr_next(n_head_ff) : n_head_ff;
      p_head_in = p_pop ? ptr_next(p_head_ff) : p_head_ff;
      n_cnt_in  = n_wr ? n_cnt_ff + CW'(1) : (n_pop ? n_cnt_ff - CW'(1) : n_cnt_ff);
      p_cnt_in  = p_wr ? p_cnt_ff + CW'(1) : (p_pop ? p_cnt_ff - CW'(1) : p_cnt_ff);

      rsp_valid_in = cmd.commit || (rsp_valid_ff && rsp_stall);
      sts.out_free = !rsp_valid_ff || !rsp_stall;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_head_ff    <= '0;
         n_tail_ff    <= '0;
         n_cnt_ff     <= '0;
         p_head_ff    <= '0;
         p_tail_ff    <= '0;
         p_cnt_ff     <= '0;
         phase_ff     <= '0;
         period_ff    <= PERIOD_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         n_head_ff    <= n_head_in;
         n_tail_ff    <= n_tail_in;
         n_cnt_ff     <= n_cnt_in;
         p_head_ff    <= p_head_in;
         p_tail_ff    <= p_tail_in;
         p_cnt_ff     <= p_cnt_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            period_ff <= csr_write_data;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

### rtl/core/tcwqs_chk.sv
// tcwqs_chk: port-level checks of the queue scheduler over time
// bound to two_class_weighted_queue_scheduler; uses tcwqs_pkg

module tcwqs_chk (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_stall,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input tcwqs_pkg::rsp_word_type        rsp_word
);
   import tcwqs_pkg::*;

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("result word changed while stalled");

   // served fields are zero unless a client was served
   a_rsp_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.status != STATUS_SERVED
         |-> rsp_word.served_id == '0 && !rsp_word.served_priority)
      else $error("served fields set on a non-serve result");

   // one word at a time: busy the cycle after an accept
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("word accepted while previous word executing");

   // no result straight out of reset
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind two_class_weighted_queue_scheduler tcwqs_chk u_tcwqs_chk (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_word       (rsp_word)
);
